// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the receiver RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/fcr_pkg.sv =====
// Types and constants shared by the framed command receiver.
`timescale 1ns / 1ps
package fcr_pkg;

  typedef enum logic [1:0] {
    StatusOk      = 2'd0,
    StatusLenErr  = 2'd1,
    StatusAddrErr = 2'd2,
    StatusEndErr  = 2'd3
  } status_e;

  typedef enum logic {
    KindStatus = 1'b0,
    KindReply  = 1'b1
  } kind_e;

  // Configuration register indexes
  localparam int unsigned CfgIdxWidth = 3;
  localparam logic [CfgIdxWidth-1:0] RegOwnAddress    = 3'd0;
  localparam logic [CfgIdxWidth-1:0] RegExpectedLength = 3'd1;
  localparam logic [CfgIdxWidth-1:0] RegStartCode     = 3'd2;
  localparam logic [CfgIdxWidth-1:0] RegEndCode       = 3'd3;
  localparam logic [CfgIdxWidth-1:0] RegReplyData     = 3'd4;

  // Reset values of the configuration registers
  localparam logic [7:0] OwnAddressRst     = 8'h03;
  localparam logic [7:0] ExpectedLengthRst = 8'h02;
  localparam logic [7:0] StartCodeRst      = 8'hFF;
  localparam logic [7:0] EndCodeRst        = 8'hEE;
  localparam logic [7:0] ReplyDataRst      = 8'hF0;

  // Reply frame beats are numbered 1..ReplyBeats after the status beat 0
  localparam int unsigned BeatWidth = 3;
  localparam logic [BeatWidth-1:0] ReplyBeats = 3'd6;

  typedef struct packed {
    logic [7:0] own_address;
    logic [7:0] expected_length;
    logic [7:0] start_code;
    logic [7:0] end_code;
    logic [7:0] reply_data;
  } cfg_t;

  // Work handed from the parser to the result sequencer
  typedef struct packed {
    logic       reply;
    status_e    status;
    logic [7:0] value;
    logic [7:0] inverse;
  } cmd_t;

endpackage

// ===== hw/rtl/fcr_front.sv =====
// Frame parser: walks the frame phases and queues status events.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fcr_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  fcr_pkg::cfg_t   cfg_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      rx_byte_i,
  input  logic            q_full_i,
  output logic            push_o,
  output fcr_pkg::cmd_t   cmd_o
);

  typedef enum logic [2:0] {
    PhHunt    = 3'd0,
    PhLength  = 3'd1,
    PhAddress = 3'd2,
    PhData    = 3'd3,
    PhCheck   = 3'd4,
    PhEnd     = 3'd5
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] held_value_q, held_value_d;
  logic [7:0] held_inverse_q, held_inverse_d;
  logic       fire;
  logic       push;
  fcr_pkg::cmd_t cmd;

  assign in_ready_o = !q_full_i;
  assign fire       = in_valid_i && in_ready_o;

  always_comb begin
    phase_d        = phase_q;
    held_value_d   = held_value_q;
    held_inverse_d = held_inverse_q;
    push           = 1'b0;
    cmd.reply      = 1'b0;
    cmd.status     = fcr_pkg::StatusOk;
    cmd.value      = held_value_q;
    cmd.inverse    = held_inverse_q;
    case (phase_q)
      PhLength: begin
        if (rx_byte_i == cfg_i.expected_length) begin
          phase_d = PhAddress;
        end else begin
          push       = 1'b1;
          cmd.status = fcr_pkg::StatusLenErr;
        end
      end
      PhAddress: begin
        if (rx_byte_i == cfg_i.own_address) begin
          phase_d = PhData;
        end else begin
          push       = 1'b1;
          cmd.status = fcr_pkg::StatusAddrErr;
        end
      end
      PhData: begin
        held_value_d = rx_byte_i;
        phase_d      = PhCheck;
      end
      PhCheck: begin
        held_inverse_d = ~rx_byte_i;
        phase_d        = PhEnd;
      end
      PhEnd: begin
        push = 1'b1;
        if (rx_byte_i == cfg_i.end_code) begin
          cmd.reply  = 1'b1;
          cmd.status = fcr_pkg::StatusOk;
        end else begin
          cmd.status = fcr_pkg::StatusEndErr;
        end
      end
      default: begin
        // hunting, and the unused phase codes behave the same
        phase_d = (rx_byte_i == cfg_i.start_code) ? PhLength : PhHunt;
      end
    endcase
    // any status ends the frame: drop held bytes and hunt again
    if (push) begin
      phase_d        = PhHunt;
      held_value_d   = 8'h00;
      held_inverse_d = 8'h00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PhHunt;
      held_value_q   <= 8'h00;
      held_inverse_q <= 8'h00;
    end else if (fire) begin
      phase_q        <= phase_d;
      held_value_q   <= held_value_d;
      held_inverse_q <= held_inverse_d;
    end
  end

  assign push_o = fire && push;
  assign cmd_o  = cmd;

  `ASSERT_HOLDS(a_ok_means_reply, clk_i, rst_ni,
                push_o |-> ((cmd_o.status == fcr_pkg::StatusOk) == cmd_o.reply),
                "good-frame status without reply, or reply on an error")
  `ASSERT_HOLDS(a_hunt_after_status, clk_i, rst_ni,
                push_o |=> (phase_q == PhHunt && held_value_q == 8'h00),
                "parser did not return to hunting after a status")

endmodule

// ===== hw/rtl/fcr_queue.sv =====
// Small register FIFO between the parser and the result sequencer.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fcr_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  fcr_pkg::cmd_t wdata_i,
  input  logic          pop_i,
  output fcr_pkg::cmd_t rdata_o,
  output logic          empty_o,
  output logic          full_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  fcr_pkg::cmd_t mem_q [Depth];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;
  logic          do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CW'(Depth));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_i && full_o,
                "push into a full command queue")

endmodule

// ===== hw/rtl/fcr_back.sv =====
// Result sequencer: turns queued events into status and reply-frame results.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fcr_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  fcr_pkg::cfg_t   cfg_i,
  input  fcr_pkg::cmd_t   head_i,
  input  logic            empty_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            kind_o,
  output logic [1:0]      status_o,
  output logic [7:0]      command_value_o,
  output logic [7:0]      inverted_copy_o,
  output logic [7:0]      tx_byte_o,
  output logic            last_o
);

  logic [fcr_pkg::BeatWidth-1:0] beat_q, beat_d;
  logic             out_valid_q;
  fcr_pkg::kind_e   kind_q, kind_d;
  fcr_pkg::status_e status_q, status_d;
  logic [7:0]       value_q, value_d;
  logic [7:0]       inverse_q, inverse_d;
  logic [7:0]       tx_q, tx_d;
  logic             last_q, last_d;
  logic             load, take, pop;
  logic [7:0]       reply_byte;

  assign load = !out_valid_q || out_ready_i;
  assign take = load && !empty_i;

  always_comb begin
    case (beat_q)
      3'd1:    reply_byte = cfg_i.start_code;
      3'd2:    reply_byte = cfg_i.expected_length;
      3'd3:    reply_byte = cfg_i.own_address;
      3'd4:    reply_byte = cfg_i.reply_data;
      3'd5:    reply_byte = ~cfg_i.reply_data;
      default: reply_byte = cfg_i.end_code;
    endcase
  end

  always_comb begin
    beat_d    = beat_q;
    pop       = 1'b0;
    kind_d    = fcr_pkg::KindStatus;
    status_d  = head_i.status;
    value_d   = head_i.value;
    inverse_d = head_i.inverse;
    tx_d      = 8'h00;
    last_d    = 1'b0;
    if (beat_q == '0) begin
      last_d = !head_i.reply;
    end else begin
      kind_d    = fcr_pkg::KindReply;
      status_d  = fcr_pkg::StatusOk;
      value_d   = 8'h00;
      inverse_d = 8'h00;
      tx_d      = reply_byte;
      last_d    = (beat_q == fcr_pkg::ReplyBeats);
    end
    if (take) begin
      // advance through the reply beats, release the event on its last result
      if (last_d) begin
        pop    = 1'b1;
        beat_d = '0;
      end else begin
        beat_d = beat_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      beat_q <= beat_d;
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      kind_q    <= kind_d;
      status_q  <= status_d;
      value_q   <= value_d;
      inverse_q <= inverse_d;
      tx_q      <= tx_d;
      last_q    <= last_d;
    end
  end

  assign pop_o           = pop;
  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign status_o        = status_q;
  assign command_value_o = value_q;
  assign inverted_copy_o = inverse_q;
  assign tx_byte_o       = tx_q;
  assign last_o          = last_q;

  `ASSERT_HOLDS(a_beat_needs_reply, clk_i, rst_ni,
                (beat_q != '0) |-> (!empty_i && head_i.reply),
                "reply beat in progress without a good-frame event at the head")
  `ASSERT_HOLDS(a_reply_ends_with_end_code, clk_i, rst_ni,
                (out_valid_o && kind_o == fcr_pkg::KindReply && last_o) |->
                  (tx_byte_o == cfg_i.end_code),
                "reply frame does not close with the end code")

endmodule

// ===== hw/rtl/framed_command_receiver.sv =====
// Framed command receiver top level: config registers, parser, queue, sequencer.
// Takes one received byte per transaction and parses six-byte frames (start,
// length, address, data, check, end). The parser accepts a byte every cycle
// while its event queue has room; a status result follows a length or address
// mismatch and the end byte, and a good frame adds six reply-byte results.
// Results leave through one output register at one per cycle while the output
// is taken, so a good frame of six bytes gives seven results. The first result
// caused by a byte enters the event queue when that byte is accepted and is then
// loaded into the output register. Configuration writes are meant for idle
// periods; the reply bytes read the registers as they stand.
`timescale 1ns / 1ps
module framed_command_receiver #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [fcr_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [7:0]                       cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [7:0]                       rx_byte_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             kind_o,
  output logic [1:0]                       status_o,
  output logic [7:0]                       command_value_o,
  output logic [7:0]                       inverted_copy_o,
  output logic [7:0]                       tx_byte_o,
  output logic                             last_o
);

  fcr_pkg::cfg_t cfg_q;
  fcr_pkg::cmd_t push_cmd, head_cmd;
  logic          push, pop, q_empty, q_full;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_address     <= fcr_pkg::OwnAddressRst;
      cfg_q.expected_length <= fcr_pkg::ExpectedLengthRst;
      cfg_q.start_code      <= fcr_pkg::StartCodeRst;
      cfg_q.end_code        <= fcr_pkg::EndCodeRst;
      cfg_q.reply_data      <= fcr_pkg::ReplyDataRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        fcr_pkg::RegOwnAddress:     cfg_q.own_address     <= cfg_data_i;
        fcr_pkg::RegExpectedLength: cfg_q.expected_length <= cfg_data_i;
        fcr_pkg::RegStartCode:      cfg_q.start_code      <= cfg_data_i;
        fcr_pkg::RegEndCode:        cfg_q.end_code        <= cfg_data_i;
        fcr_pkg::RegReplyData:      cfg_q.reply_data      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  fcr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  fcr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .pop_i   (pop),
    .rdata_o (head_cmd),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  fcr_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .head_i          (head_cmd),
    .empty_i         (q_empty),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .status_o        (status_o),
    .command_value_o (command_value_o),
    .inverted_copy_o (inverted_copy_o),
    .tx_byte_o       (tx_byte_o),
    .last_o          (last_o)
  );

endmodule

// ===== tb/framed_command_receiver_test.sv =====
// Self-checking testbench for the framed command receiver: byte stream in, results out.
`timescale 1ns / 1ps
module framed_command_receiver_test;

  typedef enum logic [2:0] {
    PhHunt    = 3'd0,
    PhLength  = 3'd1,
    PhAddress = 3'd2,
    PhData    = 3'd3,
    PhCheck   = 3'd4,
    PhEnd     = 3'd5
  } frame_phase_e;

  typedef struct packed {
    fcr_pkg::kind_e   kind;
    fcr_pkg::status_e status;
    logic [7:0]       value;
    logic [7:0]       inverse;
    logic [7:0]       tx;
    logic             last;
  } result_t;

  localparam int SettleCycles = 12;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [fcr_pkg::CfgIdxWidth-1:0] cfg_index_i = '0;
  logic [7:0]                      cfg_data_i = 8'h00;
  logic                            in_valid_i = 1'b0;
  logic                            in_ready_o;
  logic [7:0]                      rx_byte_i = 8'h00;
  logic                            out_valid_o;
  logic                            out_ready_i = 1'b0;
  logic                            kind_o;
  logic [1:0]                      status_o;
  logic [7:0]                      command_value_o;
  logic [7:0]                      inverted_copy_o;
  logic [7:0]                      tx_byte_o;
  logic                            last_o;

  // Predicted block state and register copies
  fcr_pkg::cfg_t regs = '{own_address: fcr_pkg::OwnAddressRst,
                          expected_length: fcr_pkg::ExpectedLengthRst,
                          start_code: fcr_pkg::StartCodeRst,
                          end_code: fcr_pkg::EndCodeRst,
                          reply_data: fcr_pkg::ReplyDataRst};
  frame_phase_e phase = PhHunt;
  logic [7:0]   held_value = 8'h00;
  logic [7:0]   held_inverse = 8'h00;

  logic [7:0] rx_stream [$];
  result_t    pending_results [$];
  int         bytes_queued = 0;
  int         bytes_taken = 0;
  int         send_gap = 0;
  int         stall_gap = 0;
  int         mismatches = 0;
  logic       calm = 1'b0;

  framed_command_receiver DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .status_o        (status_o),
    .command_value_o (command_value_o),
    .inverted_copy_o (inverted_copy_o),
    .tx_byte_o       (tx_byte_o),
    .last_o          (last_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #200000;
    $display("Mismatches found");
    $finish;
  end

  // Advance the frame parser by one byte and queue the results it causes.
  function automatic void parse_rx_byte(input logic [7:0] b);
    result_t          batch [$];
    result_t          beat;
    logic [47:0]      reply_frame;
    logic             report;
    fcr_pkg::status_e code;
    report = 1'b0;
    code = fcr_pkg::StatusOk;
    case (phase)
      PhLength: begin
        if (b == regs.expected_length) begin
          phase = PhAddress;
        end else begin
          report = 1'b1;
          code = fcr_pkg::StatusLenErr;
        end
      end
      PhAddress: begin
        if (b == regs.own_address) begin
          phase = PhData;
        end else begin
          report = 1'b1;
          code = fcr_pkg::StatusAddrErr;
        end
      end
      PhData: begin
        held_value = b;
        phase = PhCheck;
      end
      PhCheck: begin
        held_inverse = ~b;
        phase = PhEnd;
      end
      PhEnd: begin
        report = 1'b1;
        code = (b == regs.end_code) ? fcr_pkg::StatusOk : fcr_pkg::StatusEndErr;
      end
      default: begin
        phase = (b == regs.start_code) ? PhLength : PhHunt;
      end
    endcase
    if (report) begin
      beat = '0;
      beat.kind = fcr_pkg::KindStatus;
      beat.status = code;
      beat.value = held_value;
      beat.inverse = held_inverse;
      batch.push_back(beat);
      if (code == fcr_pkg::StatusOk) begin
        reply_frame = {regs.start_code, regs.expected_length, regs.own_address,
                       regs.reply_data, ~regs.reply_data, regs.end_code};
        for (int i = 0; i < int'(fcr_pkg::ReplyBeats); i++) begin
          beat = '0;
          beat.kind = fcr_pkg::KindReply;
          beat.tx = reply_frame[47 - 8 * i -: 8];
          batch.push_back(beat);
        end
      end
      batch[batch.size() - 1].last = 1'b1;
      phase = PhHunt;
      held_value = 8'h00;
      held_inverse = 8'h00;
    end
    foreach (batch[i]) pending_results.push_back(batch[i]);
  endfunction

  function automatic void send(input logic [7:0] b);
    rx_stream.push_back(b);
    bytes_queued++;
  endfunction

  function automatic void send_frame(input logic [7:0] s, l, a, d, c, e);
    send(s);
    send(l);
    send(a);
    send(d);
    send(c);
    send(e);
  endfunction

  // Mostly well-formed frames with random payload, the rest broken frames and noise.
  function automatic void add_random_traffic(input int count);
    int made;
    int pick;
    int noise;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(0, 19);
      if (pick < 13) begin
        send_frame(regs.start_code, regs.expected_length, regs.own_address,
                   8'($urandom), 8'($urandom), regs.end_code);
        made += 6;
      end else if (pick == 13) begin
        send(regs.start_code);
        send(regs.expected_length ^ 8'($urandom_range(1, 255)));
        made += 2;
      end else if (pick < 16) begin
        send(regs.start_code);
        send(regs.expected_length);
        send(8'($urandom));
        made += 3;
      end else if (pick < 18) begin
        send_frame(regs.start_code, regs.expected_length, regs.own_address,
                   8'($urandom), 8'($urandom), 8'($urandom));
        made += 6;
      end else begin
        noise = $urandom_range(1, 3);
        repeat (noise) send(8'($urandom));
      end
    end
  endfunction

  task automatic wait_idle();
    while (bytes_taken != bytes_queued || pending_results.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [fcr_pkg::CfgIdxWidth-1:0] idx,
                           input logic [7:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      fcr_pkg::RegOwnAddress:     regs.own_address = val;
      fcr_pkg::RegExpectedLength: regs.expected_length = val;
      fcr_pkg::RegStartCode:      regs.start_code = val;
      fcr_pkg::RegEndCode:        regs.end_code = val;
      fcr_pkg::RegReplyData:      regs.reply_data = val;
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [7:0] a, l, s, e, r);
    write_reg(fcr_pkg::RegOwnAddress, a);
    write_reg(fcr_pkg::RegExpectedLength, l);
    write_reg(fcr_pkg::RegStartCode, s);
    write_reg(fcr_pkg::RegEndCode, e);
    write_reg(fcr_pkg::RegReplyData, r);
  endtask

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  // Byte driver: hold a byte until accepted, idle in short random bursts.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        parse_rx_byte(rx_byte_i);
        bytes_taken++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (rx_stream.size() != 0 && !calm && $urandom_range(0, 6) == 0) begin
          send_gap = $urandom_range(0, 4);
          in_valid_i <= 1'b0;
        end else if (rx_stream.size() != 0) begin
          in_valid_i <= 1'b1;
          rx_byte_i <= rx_stream.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each transaction against the oldest prediction.
  always @(posedge clk_i) begin
    result_t seen;
    result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        seen.kind = fcr_pkg::kind_e'(kind_o);
        seen.status = fcr_pkg::status_e'(status_o);
        seen.value = command_value_o;
        seen.inverse = inverted_copy_o;
        seen.tx = tx_byte_o;
        seen.last = last_o;
        if (pending_results.size() == 0) begin
          note_mismatch($sformatf(
            "Unexpected result: kind %0d status %0d value %h inverse %h tx %h last %0d",
            seen.kind, seen.status, seen.value, seen.inverse, seen.tx, seen.last));
        end else begin
          want = pending_results.pop_front();
          if (seen !== want) begin
            note_mismatch($sformatf({"Result mismatch: expected kind %0d status %0d value %h ",
              "inverse %h tx %h last %0d, got kind %0d status %0d value %h inverse %h ",
              "tx %h last %0d"},
              want.kind, want.status, want.value, want.inverse, want.tx, want.last,
              seen.kind, seen.status, seen.value, seen.inverse, seen.tx, seen.last));
          end
        end
      end
      if (stall_gap > 0) begin
        stall_gap--;
        out_ready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_gap = $urandom_range(0, 4);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    // Reset settings: good frames at the data extremes, each error, ignored bytes.
    send_frame(8'hFF, 8'h02, 8'h03, 8'h00, 8'hFF, 8'hEE);
    send(8'hFF);
    send(8'hFF);  // length error on a start-code byte, not taken as a new start
    send(8'h02);  // hunting, ignored
    send(8'hFF);
    send(8'h02);
    send(8'hFF);  // address error
    send_frame(8'hFF, 8'h02, 8'h03, 8'hFF, 8'h00, 8'hFF);  // bad end byte
    send_frame(8'hFF, 8'h02, 8'h03, 8'hFF, 8'h00, 8'hEE);
    wait_idle();

    program_regs(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    add_random_traffic(50);
    wait_idle();

    program_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    add_random_traffic(50);
    wait_idle();

    program_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    add_random_traffic(50);
    wait_idle();

    program_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    calm = 1'b1;
    add_random_traffic(50);
    wait_idle();

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
